FILE: rtl/itra_pkg.sv
// Shared types, constants and helpers for the integer to radix ASCII converter.
`default_nettype none

package itra_pkg;

  localparam int unsigned DIGIT_BUFFER_DEPTH_DEF = 32;
  localparam int unsigned MAX_CHARS              = 32;

  // long division of the 32-bit magnitude, several quotient bits per cycle
  localparam int unsigned DIV_BITS           = 32;
  localparam int unsigned DIV_BITS_PER_CYCLE = 8;
  localparam int unsigned DIV_CYCLES         = DIV_BITS / DIV_BITS_PER_CYCLE;

  localparam int unsigned CFG_W     = 5;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 1'd1;

  localparam logic [4:0] RADIX_RESET = 5'd10;
  localparam logic [4:0] RADIX_MIN   = 5'd2;
  localparam logic [4:0] RADIX_MAX   = 5'd16;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  typedef enum logic [1:0] {
    OP_SIGNED   = 2'd0,
    OP_UNSIGNED = 2'd1,
    OP_POINTER  = 2'd2,
    OP_UNUSED   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } out_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CONV,
    CMD_SETUP,
    CMD_EMIT_SIGN,
    CMD_EMIT_X,
    CMD_EMIT_DIGIT
  } cmd_e;

  typedef struct packed {
    logic conv_done;
    logic is_ptr;
    logic is_neg;
    logic last_digit;
  } stat_t;

  function automatic logic [7:0] digit_ascii(input logic [3:0] d, input logic upper);
    logic [7:0] res;
    if (d < 4'd10) begin
      res = CH_ZERO + {4'b0, d};
    end else begin
      res = (upper ? CH_UPPER_A : CH_LOWER_A) + {4'b0, d} - 8'd10;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/integer_to_radix_ascii.sv
// Top level of the integer to radix ASCII converter.
// Takes one number per item and returns its ASCII characters, most significant
// first, one character per output item, with last set on the final one. Op 0
// prints the low 32 bits as signed, op 1 as unsigned, both in the configured
// radix (2..16, values outside clamp) with A-F when upper_case is set; op 2
// prints "0x" and 64-bit lowercase hex; op 3 is taken and gives nothing.
// Per item: a load, then digit extraction, a setup step, then one character
// per cycle while the output is taken. In radix modes each digit comes from a
// 32-bit long division of the magnitude by the radix, 8 quotient bits per
// cycle. In pointer mode the hex digits are shifted out of the low four bits,
// with no division. The output register lets the next item load while the
// last character still waits.
// No clearing pass after reset.
`default_nettype none

module integer_to_radix_ascii #(
  parameter int unsigned DIGIT_BUFFER_DEPTH = itra_pkg::DIGIT_BUFFER_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [itra_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [itra_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  itra_pkg::in_t                  in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output itra_pkg::out_t                 out_o
);
  import itra_pkg::*;

  cmd_e  cmd;
  stat_t stat;

  itra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_i.op),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  itra_dp #(
    .DIGIT_BUFFER_DEPTH (DIGIT_BUFFER_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

FILE: rtl/itra_dp.sv
// Datapath: config registers, digit extraction, digit buffer and output register.
`default_nettype none

module itra_dp #(
  parameter int unsigned DIGIT_BUFFER_DEPTH = itra_pkg::DIGIT_BUFFER_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [itra_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [itra_pkg::CFG_W-1:0]     cfg_data_i,
  input  itra_pkg::in_t                  in_i,
  input  itra_pkg::cmd_e                 cmd_i,
  output itra_pkg::stat_t                stat_o,
  output itra_pkg::out_t                 out_o
);
  import itra_pkg::*;

  localparam int unsigned AW  = $clog2(DIGIT_BUFFER_DEPTH);
  localparam int unsigned CW  = $clog2(DIGIT_BUFFER_DEPTH + 1);
  localparam int unsigned SW  = $clog2(DIV_CYCLES);
  localparam int unsigned ECW = $clog2(MAX_CHARS + 1);

  logic [4:0]    radix_q, radix_d;
  logic          upper_q, upper_d;
  logic [SW-1:0] step_q, step_d;
  logic [CW-1:0] wr_cnt_q, wr_cnt_d;
  logic [ECW-1:0] emit_cnt_q, emit_cnt_d;
  logic [63:0]   mag_q, mag_d;
  logic [3:0]    rem_q, rem_d;
  logic          ptr_q, ptr_d;
  logic          neg_q, neg_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [3:0]    rd_data_q;
  out_t          out_q, out_d;

  logic [3:0]    mem [DIGIT_BUFFER_DEPTH];

  logic [4:0]    eff_radix;
  logic [3:0]    div_rem;
  logic [31:0]   div_quo;
  logic [3:0]    dig;
  logic [63:0]   mag_nx;
  logic          dig_wr;
  logic          mem_we;
  logic          step_last;
  logic          buf_full;

  always_comb begin
    if (radix_q < RADIX_MIN) begin
      eff_radix = RADIX_MIN;
    end else if (radix_q > RADIX_MAX) begin
      eff_radix = RADIX_MAX;
    end else begin
      eff_radix = radix_q;
    end
  end

  // restoring division, DIV_BITS_PER_CYCLE quotient bits per cycle
  always_comb begin
    logic [4:0]  r;
    logic [31:0] m;
    r = {1'b0, rem_q};
    m = mag_q[31:0];
    for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
      r = {r[3:0], m[31]};
      m = {m[30:0], 1'b0};
      if (r >= eff_radix) begin
        r    = r - eff_radix;
        m[0] = 1'b1;
      end
    end
    div_rem = r[3:0];
    div_quo = m;
  end

  assign step_last = (step_q == SW'(DIV_CYCLES - 1));
  assign buf_full  = (wr_cnt_q == CW'(DIGIT_BUFFER_DEPTH - 1));

  always_comb begin
    if (ptr_q) begin
      dig    = mag_q[3:0];
      mag_nx = {4'b0, mag_q[63:4]};
      dig_wr = 1'b1;
    end else begin
      dig    = div_rem;
      mag_nx = {32'b0, div_quo};
      dig_wr = step_last;
    end
  end

  assign mem_we = (cmd_i == CMD_CONV) && dig_wr;

  assign stat_o.conv_done  = mem_we && ((mag_nx == 64'd0) || buf_full);
  assign stat_o.is_ptr     = ptr_q;
  assign stat_o.is_neg     = neg_q;
  assign stat_o.last_digit = (emit_cnt_q == ECW'(1));

  always_comb begin
    logic [1:0] pfx;
    logic [7:0] total;
    radix_d    = radix_q;
    upper_d    = upper_q;
    step_d     = step_q;
    wr_cnt_d   = wr_cnt_q;
    emit_cnt_d = emit_cnt_q;
    mag_d      = mag_q;
    rem_d      = rem_q;
    ptr_d      = ptr_q;
    neg_d      = neg_q;
    rd_ptr_d   = rd_ptr_q;
    out_d      = out_q;
    pfx        = ptr_q ? 2'd2 : (neg_q ? 2'd1 : 2'd0);
    total      = 8'(wr_cnt_q) + {6'b0, pfx};

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RADIX: radix_d = cfg_data_i;
        CFG_UPPER: upper_d = cfg_data_i[0];
        default: ;
      endcase
    end

    case (cmd_i)
      CMD_LOAD: begin
        ptr_d    = (in_i.op == OP_POINTER);
        neg_d    = (in_i.op == OP_SIGNED) && in_i.value[31];
        if (in_i.op == OP_POINTER) begin
          mag_d = in_i.value;
        end else if ((in_i.op == OP_SIGNED) && in_i.value[31]) begin
          mag_d = {32'b0, 32'd0 - in_i.value[31:0]};
        end else begin
          mag_d = {32'b0, in_i.value[31:0]};
        end
        rem_d    = 4'd0;
        step_d   = '0;
        wr_cnt_d = '0;
      end
      CMD_CONV: begin
        mag_d = mag_nx;
        if (dig_wr) begin
          rem_d    = 4'd0;
          step_d   = '0;
          wr_cnt_d = wr_cnt_q + CW'(1);
        end else begin
          rem_d  = div_rem;
          step_d = step_q + SW'(1);
        end
      end
      CMD_SETUP: begin
        rd_ptr_d = AW'(wr_cnt_q - CW'(1));
        if (total > 8'(MAX_CHARS)) begin
          emit_cnt_d = ECW'(8'(MAX_CHARS) - {6'b0, pfx});
        end else begin
          emit_cnt_d = ECW'(wr_cnt_q);
        end
      end
      CMD_EMIT_SIGN: begin
        out_d.char_out = ptr_q ? CH_ZERO : CH_MINUS;
        out_d.last     = 1'b0;
      end
      CMD_EMIT_X: begin
        out_d.char_out = CH_X;
        out_d.last     = 1'b0;
      end
      CMD_EMIT_DIGIT: begin
        out_d.char_out = digit_ascii(rd_data_q, upper_q && !ptr_q);
        out_d.last     = (emit_cnt_q == ECW'(1));
        rd_ptr_d       = rd_ptr_q - AW'(1);
        emit_cnt_d     = emit_cnt_q - ECW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q    <= RADIX_RESET;
      upper_q    <= 1'b0;
      step_q     <= '0;
      wr_cnt_q   <= '0;
      emit_cnt_q <= '0;
    end else begin
      radix_q    <= radix_d;
      upper_q    <= upper_d;
      step_q     <= step_d;
      wr_cnt_q   <= wr_cnt_d;
      emit_cnt_q <= emit_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    rem_q    <= rem_d;
    ptr_q    <= ptr_d;
    neg_q    <= neg_d;
    rd_ptr_q <= rd_ptr_d;
    out_q    <= out_d;
  end

  // digit buffer, least significant digit at the lowest address
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_cnt_q[AW-1:0]] <= dig;
    end
    rd_data_q <= mem[rd_ptr_d];
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

FILE: rtl/itra_ctrl.sv
// Controller: sequences load, digit extraction and character output.
`default_nettype none

module itra_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      in_op_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  itra_pkg::stat_t stat_i,
  output itra_pkg::cmd_e  cmd_o
);
  import itra_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SETUP,
    S_SIGN,
    S_XCHAR,
    S_DIGIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   emit_ok;
  logic   emit;

  assign emit_ok = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    emit    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && (in_op_i != OP_UNUSED)) begin
          cmd_o   = CMD_LOAD;
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        cmd_o = CMD_CONV;
        if (stat_i.conv_done) begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd_o   = CMD_SETUP;
        state_d = (stat_i.is_ptr || stat_i.is_neg) ? S_SIGN : S_DIGIT;
      end
      S_SIGN: begin
        if (emit_ok) begin
          cmd_o   = CMD_EMIT_SIGN;
          emit    = 1'b1;
          state_d = stat_i.is_ptr ? S_XCHAR : S_DIGIT;
        end
      end
      S_XCHAR: begin
        if (emit_ok) begin
          cmd_o   = CMD_EMIT_X;
          emit    = 1'b1;
          state_d = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (emit_ok) begin
          cmd_o = CMD_EMIT_DIGIT;
          emit  = 1'b1;
          if (stat_i.last_digit) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for integer_to_radix_ascii: random and directed items against a predictor.
`timescale 1ns / 100ps

module testbench;
  import itra_pkg::*;

  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_SEGMENTS = 10;
  localparam int ITEMS_PER_SEGMENT = 39;

  class char_scoreboard;
    logic [4:0] radix_reg;
    logic       upper_reg;
    out_t       pending_chars[$];
    int         mismatches;
    int         checked;

    function new();
      radix_reg = RADIX_RESET;
      upper_reg = 1'b0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_RADIX) begin
        radix_reg = data;
      end else begin
        upper_reg = data[0];
      end
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction

    // works out the characters of one accepted item
    function void note_input(in_t item);
      logic [63:0] mag;
      logic [4:0]  base;
      logic        up;
      logic [3:0]  d;
      logic [7:0]  digit_chars[$];
      logic [7:0]  text[$];
      out_t        e;
      if (item.op == OP_UNUSED) return;
      if (item.op == OP_POINTER) begin
        base = 5'd16;
        up = 1'b0;
        mag = item.value;
        text.push_back(CH_ZERO);
        text.push_back(CH_X);
      end else begin
        base = (radix_reg < RADIX_MIN) ? RADIX_MIN :
               (radix_reg > RADIX_MAX) ? RADIX_MAX : radix_reg;
        up = upper_reg;
        mag = {32'b0, item.value[31:0]};
        if (item.op == OP_SIGNED && mag[31]) begin
          mag = {32'b0, 32'(~mag[31:0] + 32'd1)};
          text.push_back(CH_MINUS);
        end
      end
      if (mag == 64'd0) digit_chars.push_front(CH_ZERO);
      while (mag != 64'd0 && digit_chars.size() < DIGIT_BUFFER_DEPTH_DEF) begin
        d = 4'(mag % base);
        digit_chars.push_front((d < 4'd10) ? CH_ZERO + 8'(d) :
                               (up ? CH_UPPER_A : CH_LOWER_A) + 8'(d) - 8'd10);
        mag = mag / base;
      end
      // the signed minimum in binary overflows the line, so it gets cut
      foreach (digit_chars[k]) begin
        if (text.size() < MAX_CHARS) text.push_back(digit_chars[k]);
      end
      foreach (text[k]) begin
        e.char_out = text[k];
        e.last = (k == text.size() - 1);
        pending_chars.push_back(e);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      checked++;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character, expected none actual %h last %b",
                 $time, got.char_out, got.last);
        mismatches++;
        return;
      end
      want = pending_chars.pop_front();
      if (got.char_out !== want.char_out) begin
        $display("%0t: char_out mismatch, expected %h actual %h",
                 $time, want.char_out, got.char_out);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch, expected %b actual %b", $time, want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_RADIX;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  in_t                  in_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_t                 out_o;

  char_scoreboard board = new();

  int send_idle_pct = 23;
  int recv_idle_pct = 65;
  int items_sent = 0;
  int op_count[4] = '{0, 0, 0, 0};
  int settings_used = 1;

  integer_to_radix_ascii uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_o);
  end

  task automatic send_item(input in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_input(item);
    op_count[item.op]++;
    items_sent++;
    if (items_sent < 137) begin
      send_idle_pct = 23;
      recv_idle_pct = 65;
    end else if (items_sent < 274) begin
      send_idle_pct = 65;
      recv_idle_pct = 23;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  task automatic send(input op_e op, input logic [63:0] value);
    in_t item;
    item.op = op;
    item.value = value;
    send_item(item);
  endtask

  // hold the sender off until every character is out and unused items have drained
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [4:0] radix, input logic upper);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_RADIX;
    cfg_data_i <= radix;
    @(posedge clk_i);
    cfg_idx_i <= CFG_UPPER;
    cfg_data_i <= {4'b0, upper};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.write_reg(CFG_RADIX, radix);
    board.write_reg(CFG_UPPER, {4'b0, upper});
    settings_used++;
  endtask

  function automatic in_t random_item();
    in_t         item;
    int unsigned pick;
    pick = $urandom_range(99);
    item.op = (pick < 5) ? OP_UNUSED : (pick < 40) ? OP_SIGNED :
              (pick < 75) ? OP_UNSIGNED : OP_POINTER;
    item.value = {$urandom, $urandom};
    case ($urandom_range(5))
      0: item.value[31:0] = $urandom_range(255);
      1: item.value[31:0] = 32'h8000_0000 ^ $urandom_range(3);
      2: item.value[31:0] = 32'hffff_ffff - $urandom_range(3);
      3: item.value = 64'($urandom_range(15));
      default: ;
    endcase
    return item;
  endfunction

  initial begin
    int          seg_radix[8] = '{0, 31, 7, 16, 1, 17, 2, 10};
    logic [4:0]  radix;
    logic        upper;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: decimal, lowercase
    send(OP_SIGNED, 64'd0);
    send(OP_SIGNED, 64'h0000_0000_7fff_ffff);
    send(OP_SIGNED, 64'h0000_0000_8000_0000);
    send(OP_SIGNED, 64'hffff_ffff_ffff_ffff);
    send(OP_SIGNED, 64'hdead_beef_0000_007b);
    send(OP_UNSIGNED, 64'h0000_0000_ffff_ffff);
    send(OP_UNSIGNED, 64'hffff_ffff_0000_0000);
    send(OP_POINTER, 64'd0);
    send(OP_POINTER, 64'hffff_ffff_ffff_ffff);
    send(OP_POINTER, 64'h0123_4567_89ab_cdef);
    send(OP_UNUSED, 64'h5a5a_a5a5_1234_5678);

    drain();
    configure(RADIX_MIN, 1'b0);
    send(OP_SIGNED, 64'h0000_0000_8000_0000);
    send(OP_UNSIGNED, 64'h0000_0000_ffff_ffff);
    send(OP_SIGNED, 64'hffff_ffff_ffff_ffff);

    drain();
    configure(RADIX_MAX, 1'b1);
    send(OP_UNSIGNED, 64'h0000_0000_dead_beef);
    send(OP_SIGNED, 64'h0000_0000_8000_0000);
    send(OP_POINTER, 64'hfedc_ba98_abcd_ef01);

    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      drain();
      if (seg < 8) begin
        radix = 5'(seg_radix[seg]);
        upper = seg[0];
      end else begin
        radix = 5'($urandom_range(31));
        upper = 1'($urandom_range(1));
      end
      configure(radix, upper);
      repeat (ITEMS_PER_SEGMENT) send_item(random_item());
    end

    drain();
    $display("Sent %0d items (signed %0d, unsigned %0d, pointer %0d, unused %0d)",
             items_sent, op_count[OP_SIGNED], op_count[OP_UNSIGNED],
             op_count[OP_POINTER], op_count[OP_UNUSED]);
    $display("Checked %0d characters over %0d register settings, %0d mismatches",
             board.checked, settings_used, board.mismatches);
    if (board.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d characters outstanding", board.pending());
    $display("FAIL");
    $finish;
  end

endmodule
